/* rtl/spd_pkg.sv */
// Shared types and constants of the encoder speed PID controller.
package spd_pkg;

   localparam int ACC_FRAC_BITS = 16;
   localparam int SCALE_SH      = ACC_FRAC_BITS - 8;

   // Field widths.
   localparam int TGT_W   = 14;
   localparam int GAIN_W  = 16;
   localparam int PPR_W   = 20;
   localparam int LIM_W   = 14;
   localparam int CNT_W   = 16;
   localparam int MS_W    = 16;
   localparam int DUTY_W  = 8;
   localparam int RPM_W   = 16;
   localparam int ERR_W   = 26;
   localparam int ACC_W   = 32;
   localparam int RATE_W  = 36;
   localparam int SUM_W   = 56;

   // Shared multiplier operand and product widths.
   localparam int MA_W = 17;
   localparam int MB_W = 40;
   localparam int MP_W = MA_W + MB_W;

   // Shared divider widths.
   localparam int DVD_W = (ACC_FRAC_BITS > 16) ? (34 + ACC_FRAC_BITS) : 50;
   localparam int DVS_W = 36;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   // Division by 1000 in 16-bit digits, each digit by reciprocal multiplication.
   localparam int CD_DIG   = (DVD_W + 15) / 16;
   localparam int CD_W     = 16 * CD_DIG;
   localparam int CD_CNT_W = $clog2(CD_DIG + 1);
   localparam int CD_SH    = 36;
   localparam logic [26:0] CD_RECIP = 27'd68719477;
   localparam logic [25:0] CD_DIV   = 26'd1000;

   // Delta of the integral and the wider sum before clamping.
   localparam int DLT_W = ACC_FRAC_BITS + 26;

   // 60e6 * 256: pulses per rev are given times 1000, period in ms, speed in Q.8.
   localparam logic [MB_W-1:0] SPEED_K   = 40'd15360000000;
   localparam logic [MS_W-1:0] MS_MIN    = 16'd10;
   localparam logic [MA_W-1:0] MILLI     = 17'd1000;
   localparam logic [39:0]     ACC_MAX   = 40'd2147483647;
   localparam logic [SUM_W-1:0] SUM_TOP  = 56'd16711680;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
   localparam logic [RPM_W-1:0]  RPM_MAX  = 16'd65535;

   // Register indexes.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET   = 3'd0,
      REG_KP       = 3'd1,
      REG_KI       = 3'd2,
      REG_KD       = 3'd3,
      REG_PPR      = 3'd4,
      REG_LIMIT    = 3'd5
   } reg_idx_type;

   localparam logic [TGT_W-1:0]  TARGET_RST = 14'd500;
   localparam logic [GAIN_W-1:0] KP_RST     = 16'd128;
   localparam logic [GAIN_W-1:0] KI_RST     = 16'd141;
   localparam logic [GAIN_W-1:0] KD_RST     = 16'd0;
   localparam logic [PPR_W-1:0]  PPR_RST    = 20'd62184;
   localparam logic [LIM_W-1:0]  LIMIT_RST  = 14'd10000;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL_NUM,
      OP_MUL_DEN,
      OP_DIV_SPEED,
      OP_ERR,
      OP_MUL_EMS,
      OP_DIV_DELTA,
      OP_ACC,
      OP_MUL_DIFF,
      OP_DIV_RATE,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_SUM,
      OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_DIV_SPEED,
      ST_WAIT_SPEED,
      ST_ERR,
      ST_MUL_EMS,
      ST_DIV_DELTA,
      ST_WAIT_DELTA,
      ST_ACC,
      ST_MUL_DIFF,
      ST_DIV_RATE,
      ST_WAIT_RATE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage

/* rtl/spd_div.sv */
// Dividers: restoring unsigned divider, one quotient bit per cycle, and division by 1000.
module spd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [spd_pkg::DVD_W-1:0] dividend,
   input  logic [spd_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [spd_pkg::DVD_W-1:0] quotient
);
   import spd_pkg::*;

   logic [DVD_W-1:0]  quot_ff, quot_in;
   logic [DVS_W:0]    rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W+1:0]  rem_sh;
   logic [DVS_W+1:0]  rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[DVD_W-1]};
      rem_sub = rem_sh - {2'b00, dvs_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DCNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_sub[DVS_W+1]) begin
            rem_in  = rem_sub[DVS_W:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DVS_W:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// Unsigned division by 1000, one 16-bit digit of the dividend per cycle, top digit first.
module spd_cdiv (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [spd_pkg::DVD_W-1:0] dividend,
   output logic                      done,
   output logic [spd_pkg::DVD_W-1:0] quotient
);
   import spd_pkg::*;

   logic [CD_W-1:0]     num_ff, num_in;
   logic [CD_W-1:0]     quot_ff, quot_in;
   logic [9:0]          rem_ff, rem_in;
   logic [CD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [25:0]         part;
   logic [52:0]         recip_prod;
   logic [15:0]         digit_q;
   logic [25:0]         part_rem;

   always_comb begin
      // The remainder stays below 1000, so the partial dividend fits in 26 bits
      // and the reciprocal gives the exact digit.
      part       = {rem_ff, num_ff[CD_W-1 -: 16]};
      recip_prod = {27'd0, part} * {26'd0, CD_RECIP};
      digit_q    = recip_prod[CD_SH+15:CD_SH];
      part_rem   = part - {10'd0, digit_q} * CD_DIV;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = CD_W'(dividend);
         quot_in = '0;
         rem_in  = '0;
         cnt_in  = CD_CNT_W'(CD_DIG);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[CD_W-17:0], 16'd0};
         quot_in = {quot_ff[CD_W-17:0], digit_q};
         rem_in  = part_rem[9:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CD_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff[DVD_W-1:0];

endmodule

/* rtl/spd_dp.sv */
// Datapath: settings, shared multiplier, shared divider and divide-by-1000 unit, PID state and result word.
module spd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  spd_pkg::cmd_type              cmd,
   output spd_pkg::stat_type             stat,
   input  logic                          csr_we,
   input  logic [spd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spd_pkg::CSR_DAT_W-1:0] csr_data,
   input  logic [31:0]                   req_tdata,
   output logic [31:0]                   rsp_tdata
);
   import spd_pkg::*;

   logic [TGT_W-1:0]  target_ff;
   logic [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [PPR_W-1:0]  ppr_ff;
   logic [LIM_W-1:0]  limit_ff;

   logic [CNT_W-1:0]        cnt_ff;
   logic [MS_W-1:0]         ms_ff;
   logic [DVD_W-1:0]        num_ff;
   logic signed [MP_W-1:0]  prod_ff;
   logic signed [ERR_W-1:0] err_ff, last_ff;
   logic signed [ACC_W-1:0] integ_ff;
   logic signed [RATE_W-1:0] rate_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    neg_ff;
   logic                    iflag_ff;
   logic [RPM_W-1:0]        rpm_ff;
   logic [RPM_W-1:0]        rpm_out_ff;
   logic [DUTY_W-1:0]       duty_ff;
   logic                    dsat_ff;
   logic                    oflag_ff;

   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic                    div_start;
   logic [DVD_W-1:0]        div_dvd;
   logic [DVS_W-1:0]        div_dvs;
   logic                    div_done;
   logic [DVD_W-1:0]        div_quot;
   logic                    cdiv_start;
   logic [DVD_W-1:0]        cdiv_dvd;
   logic                    cdiv_done;
   logic [DVD_W-1:0]        cdiv_quot;

   logic [MS_W-1:0]         req_ms;
   logic [PPR_W-1:0]        ppr_eff;
   logic [MP_W-1:0]         prod_abs;
   logic signed [DVD_W+1:0] err_wide;
   logic signed [ERR_W-1:0] err_sat;
   logic [RPM_W-1:0]        rpm_val;
   logic signed [DLT_W-1:0] delta;
   logic signed [DLT_W:0]   acc_sum;
   logic [39:0]             lim_wide;
   logic signed [DLT_W:0]   lim;
   logic signed [ERR_W:0]   err_diff;
   logic signed [RATE_W-1:0] rate_val;
   logic signed [MP_W-1:0]  integ_term;
   logic [DUTY_W-1:0]       duty_val;
   logic                    dsat_val;

   spd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quot)
   );

   spd_cdiv u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cdiv_start),
      .dividend (cdiv_dvd),
      .done     (cdiv_done),
      .quotient (cdiv_quot)
   );

   // Only one of the two dividers runs at a time.
   assign stat.div_done = div_done || cdiv_done;

   always_comb begin
      req_ms   = (req_tdata[31:16] < MS_MIN) ? MS_MIN : req_tdata[31:16];
      ppr_eff  = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
      prod_abs = prod_ff[MP_W-1] ? MP_W'(-prod_ff) : MP_W'(prod_ff);

      // Speed error, saturated to the error range.
      err_wide = $signed({2'b00, DVD_W'({target_ff, 8'd0})}) - $signed({2'b00, div_quot});
      if (err_wide > (DVD_W+2)'(2**(ERR_W-1) - 1))
         err_sat = ERR_W'(2**(ERR_W-1) - 1);
      else if (err_wide < -(DVD_W+2)'(2**(ERR_W-1)))
         err_sat = ERR_W'(-(2**(ERR_W-1)));
      else
         err_sat = err_wide[ERR_W-1:0];
      rpm_val = (div_quot[DVD_W-1:RPM_W+8] != '0) ? RPM_MAX : div_quot[RPM_W+7:8];

      delta    = neg_ff ? -DLT_W'(cdiv_quot) : DLT_W'(cdiv_quot);
      acc_sum  = (DLT_W+1)'(integ_ff) + (DLT_W+1)'(delta);
      lim_wide = 40'(limit_ff) << ACC_FRAC_BITS;
      lim      = (lim_wide > ACC_MAX) ? (DLT_W+1)'(ACC_MAX) : (DLT_W+1)'(lim_wide);

      err_diff = (ERR_W+1)'(err_ff) - (ERR_W+1)'(last_ff);
      rate_val = neg_ff ? -RATE_W'(div_quot) : RATE_W'(div_quot);

      // Integral term divided by the scale, rounded toward zero.
      if (prod_ff[MP_W-1])
         integ_term = (prod_ff + MP_W'((2**SCALE_SH) - 1)) >>> SCALE_SH;
      else
         integ_term = prod_ff >>> SCALE_SH;

      dsat_val = 1'b0;
      if (sum_ff[SUM_W-1]) begin
         duty_val = '0;
         dsat_val = 1'b1;
      end else if (sum_ff > $signed(SUM_TOP)) begin
         duty_val = DUTY_MAX;
         dsat_val = 1'b1;
      end else begin
         duty_val = sum_ff[23:16];
      end
   end

   // Multiplier and divider operand selection.
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_dvd    = num_ff;
      div_dvs    = prod_ff[DVS_W-1:0];
      cdiv_start = 1'b0;
      cdiv_dvd   = DVD_W'(prod_abs) << SCALE_SH;
      case (cmd.op)
         OP_MUL_NUM: begin
            mul_a = MA_W'({1'b0, cnt_ff});
            mul_b = SPEED_K;
         end
         OP_MUL_DEN: begin
            mul_a = MA_W'({1'b0, ms_ff});
            mul_b = MB_W'(ppr_eff);
         end
         OP_DIV_SPEED: div_start = 1'b1;
         OP_MUL_EMS: begin
            mul_a = MA_W'({1'b0, ms_ff});
            mul_b = MB_W'(err_ff);
         end
         OP_DIV_DELTA: cdiv_start = 1'b1;
         OP_MUL_DIFF: begin
            mul_a = MILLI;
            mul_b = MB_W'(err_diff);
         end
         OP_DIV_RATE: begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(prod_abs);
            div_dvs   = DVS_W'(ms_ff);
         end
         OP_MUL_P: begin
            mul_a = MA_W'({1'b0, kp_ff});
            mul_b = MB_W'(err_ff);
         end
         OP_MUL_I: begin
            mul_a = MA_W'({1'b0, ki_ff});
            mul_b = MB_W'(integ_ff);
         end
         OP_MUL_D: begin
            mul_a = MA_W'({1'b0, kd_ff});
            mul_b = MB_W'(rate_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= MP_W'(mul_a) * MP_W'(mul_b);
      case (cmd.op)
         OP_LOAD: begin
            cnt_ff <= req_tdata[15:0];
            ms_ff  <= req_ms;
         end
         OP_MUL_DEN:   num_ff <= prod_ff[DVD_W-1:0];
         OP_ERR: begin
            err_ff <= err_sat;
            rpm_ff <= rpm_val;
         end
         OP_DIV_DELTA: neg_ff <= prod_ff[MP_W-1];
         OP_DIV_RATE:  neg_ff <= prod_ff[MP_W-1];
         OP_MUL_P:     rate_ff <= rate_val;
         OP_MUL_I:     sum_ff <= SUM_W'(prod_ff);
         OP_MUL_D:     sum_ff <= sum_ff + SUM_W'(integ_term);
         OP_SUM:       sum_ff <= sum_ff + SUM_W'(prod_ff);
         OP_OUT: begin
            duty_ff    <= duty_val;
            dsat_ff    <= dsat_val;
            oflag_ff   <= iflag_ff;
            rpm_out_ff <= rpm_ff;
         end
         default: ;
      endcase
   end

   // Controller state that survives between ticks, and the settings.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff  <= '0;
         last_ff   <= '0;
         iflag_ff  <= 1'b0;
         target_ff <= TARGET_RST;
         kp_ff     <= KP_RST;
         ki_ff     <= KI_RST;
         kd_ff     <= KD_RST;
         ppr_ff    <= PPR_RST;
         limit_ff  <= LIMIT_RST;
      end else begin
         if (cmd.op == OP_ACC) begin
            if (acc_sum > lim) begin
               integ_ff <= ACC_W'(lim);
               iflag_ff <= 1'b1;
            end else if (acc_sum < -lim) begin
               integ_ff <= ACC_W'(-lim);
               iflag_ff <= 1'b1;
            end else begin
               integ_ff <= ACC_W'(acc_sum);
               iflag_ff <= 1'b0;
            end
         end
         if (cmd.op == OP_MUL_DIFF) last_ff <= err_ff;
         if (csr_we) begin
            unique case (csr_index)
               REG_TARGET: target_ff <= csr_data[TGT_W-1:0];
               REG_KP:     kp_ff     <= csr_data[GAIN_W-1:0];
               REG_KI:     ki_ff     <= csr_data[GAIN_W-1:0];
               REG_KD:     kd_ff     <= csr_data[GAIN_W-1:0];
               REG_PPR:    ppr_ff    <= csr_data[PPR_W-1:0];
               REG_LIMIT:  limit_ff  <= csr_data[LIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tdata = {6'd0, oflag_ff, dsat_ff, rpm_out_ff, duty_ff};

endmodule

/* rtl/spd_ctrl.sv */
// Sequencer that steps the datapath through one control tick.
module spd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  spd_pkg::stat_type stat,
   output spd_pkg::cmd_type  cmd
);
   import spd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_MUL_NUM;
         ST_MUL_NUM:    state_in = ST_MUL_DEN;
         ST_MUL_DEN:    state_in = ST_DIV_SPEED;
         ST_DIV_SPEED:  state_in = ST_WAIT_SPEED;
         ST_WAIT_SPEED: if (stat.div_done) state_in = ST_ERR;
         ST_ERR:        state_in = ST_MUL_EMS;
         ST_MUL_EMS:    state_in = ST_DIV_DELTA;
         ST_DIV_DELTA:  state_in = ST_WAIT_DELTA;
         ST_WAIT_DELTA: if (stat.div_done) state_in = ST_ACC;
         ST_ACC:        state_in = ST_MUL_DIFF;
         ST_MUL_DIFF:   state_in = ST_DIV_RATE;
         ST_DIV_RATE:   state_in = ST_WAIT_RATE;
         ST_WAIT_RATE:  if (stat.div_done) state_in = ST_MUL_P;
         ST_MUL_P:      state_in = ST_MUL_I;
         ST_MUL_I:      state_in = ST_MUL_D;
         ST_MUL_D:      state_in = ST_SUM;
         ST_SUM:        state_in = ST_OUT;
         ST_OUT:        if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = OP_IDLE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         ST_MUL_NUM:   cmd.op = OP_MUL_NUM;
         ST_MUL_DEN:   cmd.op = OP_MUL_DEN;
         ST_DIV_SPEED: cmd.op = OP_DIV_SPEED;
         ST_ERR:       cmd.op = OP_ERR;
         ST_MUL_EMS:   cmd.op = OP_MUL_EMS;
         ST_DIV_DELTA: cmd.op = OP_DIV_DELTA;
         ST_ACC:       cmd.op = OP_ACC;
         ST_MUL_DIFF:  cmd.op = OP_MUL_DIFF;
         ST_DIV_RATE:  cmd.op = OP_DIV_RATE;
         ST_MUL_P:     cmd.op = OP_MUL_P;
         ST_MUL_I:     cmd.op = OP_MUL_I;
         ST_MUL_D:     cmd.op = OP_MUL_D;
         ST_SUM:       cmd.op = OP_SUM;
         ST_OUT:       if (out_free) cmd.op = OP_OUT;
         default:      cmd.op = OP_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/encoder_speed_pid_unit.sv */
// Top level of the encoder speed PID controller.
//
//   channel  dir  word contents (low bit first)
//   req      in   pulse_count[15:0], elapsed_ms[31:16]
//   rsp      out  pwm_duty[7:0], measured_rpm[23:8], drive_saturated[24],
//                 integral_clamped[25], zero pad
//   csr      in   csr_index selects the register, csr_data holds its value
//
// A tick passes twice through the shared one-bit-per-cycle divider, once through
// the division by 1000 in four 16-bit digits, and through the multiply, error,
// integral, sum and output steps. Ticks are processed one at a time; the next
// word can be accepted in the same cycle as the result appears in the output
// register, and a result that is not taken holds the next tick in its last step.
// Reset is synchronous and restores the register defaults and clears the
// integral and last error.
module encoder_speed_pid_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // pulse_count, elapsed_ms
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // pwm_duty, measured_rpm,
                                                     // drive_saturated, integral_clamped
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spd_pkg::CSR_DAT_W-1:0] csr_data
);
   import spd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   spd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* rtl/spd_chk.sv */
// Port-level checker for the encoder speed PID controller, bound to the top level.
module spd_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A tick stays in flight after it is accepted, and no new tick is taken meanwhile.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new tick taken while one is in flight");

   // A saturated drive shows either the bottom or the top duty.
   a_sat_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> (rsp_tdata[7:0] == 8'd0 || rsp_tdata[7:0] == 8'd255))
      else $error("saturation flag without an end-stop duty");

endmodule

bind encoder_speed_pid_unit spd_chk u_spd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
